/* rtl/core/xce_pkg.sv */
// Shared types, constants and key-schedule function for the XTEA CBC encrypt unit.
package xce_pkg;

    typedef logic [31:0] word_t;
    typedef logic [3:0][31:0] key_t;

    localparam word_t PAD_WORD = 32'h0404_0404;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IV1  = 3'd5;

    typedef struct packed {
        logic  phase;
        word_t sum;
    } round_ctl_t;

    // every fourth key bit, MSB-first across the key words, MSB of delta first
    function automatic word_t derive_delta(key_t k);
        word_t d;
        d = '0;
        for (int n = 0; n < 32; n++)
        begin
            d[31-n] = k[n >> 3][31 - ((n << 2) & 31)];
        end
        return d;
    endfunction

endpackage

/* rtl/core/xtea_cbc_encrypt_unit.sv */
// XTEA CBC encrypt unit: one shared half-round unit stepped by a sequencer.
// Sequence: an accepted request leaves idle for the round state, then the done state, where the
// result is registered once the output is free; the next request is taken only back in idle.
// Each round takes two passes through the single half-round unit, one for each word.
// Key error requests skip the rounds and go from accept straight to the done state.
// Reset clears key, IV and chain to zero and selects the IV for the first block.
module xtea_cbc_encrypt_unit
    import xce_pkg::*;
#(
    parameter int ROUNDS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          plain_first,
    input  logic [31:0]          plain_second,
    input  logic [1:0]           valid_words,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          cipher_first,
    output logic [31:0]          cipher_second,
    output logic                 key_error
);

    localparam int CW = $clog2(ROUNDS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    key_t          key_reg;
    word_t         iv0_reg, iv1_reg;
    word_t         chain0_reg, chain1_reg;
    logic          use_iv_reg, use_iv_next;
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          phase_reg, phase_next;
    logic          err_reg, err_next;
    word_t         x_reg, x_next, y_reg, y_next, sum_reg, sum_next;
    word_t         delta;
    logic          out_valid_reg, out_valid_next;
    word_t         c0_reg, c1_reg;
    logic          kerr_reg;
    logic          in_acc, out_free, last_step, retire;
    word_t         p1, ch0, ch1, f;
    round_ctl_t    ctl;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign delta     = derive_delta(key_reg);
    assign last_step = phase_reg && (cnt_reg == CW'(ROUNDS - 1));
    assign retire    = (state_reg == ST_DONE) && out_free;

    assign out_valid     = out_valid_reg;
    assign cipher_first  = c0_reg;
    assign cipher_second = c1_reg;
    assign key_error     = kerr_reg;

    assign p1  = (valid_words == 2'd1) ? PAD_WORD : plain_second;
    assign ch0 = (restart || use_iv_reg) ? iv0_reg : chain0_reg;
    assign ch1 = (restart || use_iv_reg) ? iv1_reg : chain1_reg;

    assign ctl.phase = phase_reg;
    assign ctl.sum   = sum_reg;

    xce_round u_round
    (
        .v   (phase_reg ? x_reg : y_reg),
        .key (key_reg),
        .ctl (ctl),
        .f   (f)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        err_next       = err_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sum_next       = sum_reg;
        use_iv_next    = use_iv_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    sum_next   = '0;
                    if (delta == '0)
                    begin
                        err_next   = 1'b1;
                        x_next     = '0;
                        y_next     = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        x_next     = plain_first ^ ch0;
                        y_next     = p1 ^ ch1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    x_next   = x_reg + f;
                    sum_next = sum_reg + delta;
                end
                else
                begin
                    y_next   = y_reg + f;
                    cnt_next = cnt_reg + CW'(1);
                    if (last_step)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (!err_reg)
                    begin
                        use_iv_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            iv0_reg       <= '0;
            iv1_reg       <= '0;
            chain0_reg    <= '0;
            chain1_reg    <= '0;
            use_iv_reg    <= 1'b1;
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            use_iv_reg    <= use_iv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_KEY0: key_reg[0] <= cfg_data;
                    REG_KEY1: key_reg[1] <= cfg_data;
                    REG_KEY2: key_reg[2] <= cfg_data;
                    REG_KEY3: key_reg[3] <= cfg_data;
                    REG_IV0:  iv0_reg    <= cfg_data;
                    REG_IV1:  iv1_reg    <= cfg_data;
                    default:  ;
                endcase
            end
            if (retire && !err_reg)
            begin
                chain0_reg <= x_reg;
                chain1_reg <= y_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        sum_reg <= sum_next;
        if (retire)
        begin
            c0_reg   <= x_reg;
            c1_reg   <= y_reg;
            kerr_reg <= err_reg;
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kerr_reg |-> (c0_reg == '0) && (c1_reg == '0))
        else $error("key error result carries nonzero ciphertext");

    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (delta != '0) |=> (state_reg == ST_RUN) && (cnt_reg == '0) && !phase_reg)
        else $error("accepted request did not start rounds");

    a_chain_used: assert property (@(posedge clk) disable iff (!rst_n)
        retire && !err_reg |=> !use_iv_reg && out_valid_reg)
        else $error("completed block did not update chain state");

    a_err_keeps_chain: assert property (@(posedge clk) disable iff (!rst_n)
        retire && err_reg |=> $stable(chain0_reg) && $stable(chain1_reg))
        else $error("key error changed chain value");
`endif

endmodule

/* rtl/core/xce_round.sv */
// XTEA half-round function: mix of one word with the keyed running sum.
module xce_round
    import xce_pkg::*;
(
    input  word_t      v,
    input  key_t       key,
    input  round_ctl_t ctl,
    output word_t      f
);

    logic [1:0] idx;
    word_t      mix;
    word_t      ks;

    assign idx = ctl.phase ? ctl.sum[12:11] : ctl.sum[1:0];
    assign mix = ((v << 4) ^ (v >> 5)) + v;
    assign ks  = ctl.sum + key[idx];
    assign f   = mix ^ ks;

endmodule
